@@ hw/rtl/radix_text_to_integer_parser_macros.svh @@
// Assertion macros for the text-to-integer parser.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RADIX_TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define RADIX_TEXT_TO_INTEGER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define RTIP_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rtip assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define RTIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtip assertion failed");

`else

`define RTIP_ASSERT(label, cond)
`define RTIP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hw/rtl/rtip_pkg.sv @@
package rtip_pkg;

    // Default sizes of the accumulator and the position counter.
    localparam int VALUE_BITS_DEF    = 64;
    localparam int POSITION_BITS_DEF = 16;

    // Fixed port widths.
    localparam int BYTE_W      = 8;
    localparam int RADIX_W     = 6;
    localparam int OUT_VALUE_W = 64;
    localparam int LENGTH_W    = 16;
    localparam int APB_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int REG_IDX_W   = CFG_ADDR_W - 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_RADIX = '0;

    // Bases and radix limits.
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_BAD    = 6'd1;
    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] ALPHA_BASE  = 6'd10;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;

    // Parse phases, one-hot.
    typedef enum logic [5:0] {
        PH_SPACE   = 6'b000001,
        PH_START   = 6'b000010,
        PH_ZERO    = 6'b000100,
        PH_AFTER_X = 6'b001000,
        PH_DIGITS  = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    // Decoded digit of one character.
    typedef struct packed {
        logic               ok;
        logic [RADIX_W-1:0] value;
    } digit_t;

    // One result word.
    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] parsed_value;
        logic [LENGTH_W-1:0]           consumed_length;
        logic                          overflow;
    } result_t;

    // Map a character to its digit value 0..35.
    function automatic digit_t char_digit(input logic [BYTE_W-1:0] c);
        digit_t d;
        d.ok    = 1'b1;
        d.value = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = RADIX_W'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d.value = RADIX_W'(c - CH_LO_A) + ALPHA_BASE;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d.value = RADIX_W'(c - CH_UP_A) + ALPHA_BASE;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ hw/rtl/rtip_if.sv @@
// Text channel: one character word per handshake.
interface rtip_text_if
    import rtip_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

// Result channel: one word per parsed text.
interface rtip_result_if
    import rtip_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [OUT_VALUE_W-1:0] parsed_value;
    logic [LENGTH_W-1:0]           consumed_length;
    logic                          overflow;

    modport source (output valid, output parsed_value, output consumed_length,
                    output overflow, input ready);
    modport sink (input valid, input parsed_value, input consumed_length,
                  input overflow, output ready);
endinterface

@@ hw/rtl/rtip_cfg.sv @@
module rtip_cfg
    import rtip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [RADIX_W-1:0]    radix
);

    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   radix_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_RADIX);
    assign pready  = 1'b1;

    // Write decode for the radix register.
    always_comb
    begin
        radix_next = radix_reg;
        if (wr_en)
        begin
            radix_next = pwdata[RADIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // Read mux; addresses beyond the register list read as zero.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_RADIX)
        begin
            prdata = APB_DATA_W'(radix_reg);
        end
    end

    assign radix = radix_reg;

endmodule

@@ hw/rtl/rtip_core.sv @@
module rtip_core
    import rtip_pkg::*;
#(
    parameter int VALUE_BITS    = VALUE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [BYTE_W-1:0]  text_byte,
    input  logic               last_byte,
    input  logic [RADIX_W-1:0] radix,
    output logic               emit,
    output result_t            res
);

    localparam int MAC_W = VALUE_BITS + RADIX_W + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Text state.
    phase_t                   phase_reg, phase_next;
    logic                     neg_reg, neg_next;
    logic [RADIX_W-1:0]       base_reg, base_next;
    logic [VALUE_BITS-1:0]    acc_reg, acc_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] ds_reg, ds_next;
    logic [POSITION_BITS-1:0] ce_reg, ce_next;
    logic                     ovf_reg, ovf_next;

    // Per-character decode.
    digit_t                   dig;
    logic                     is_space;
    logic                     radix_bad;
    logic                     take_start;
    logic                     use_digit;
    logic [RADIX_W-1:0]       dig_base;
    logic                     dig_ok;
    logic [MAC_W-1:0]         mac;
    logic                     text_end;
    logic [POSITION_BITS-1:0] ce_final;
    logic [VALUE_BITS-1:0]    mag_signed;
    logic signed [VALUE_BITS-1:0] val_s;

    assign dig       = char_digit(text_byte);
    assign is_space  = (text_byte == CH_SPACE) || (text_byte >= CH_TAB && text_byte <= CH_CR);
    assign radix_bad = (radix == BASE_BAD) || (radix > RADIX_MAX);

    // Phase logic for one character.
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        ds_next    = ds_reg;
        ce_next    = ce_reg;
        ovf_next   = ovf_reg;
        take_start = 1'b0;
        use_digit  = 1'b0;
        dig_base   = base_reg;
        dig_ok     = 1'b0;
        mac        = '0;

        if (text_byte != CH_NUL)
        begin
            pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

            case (phase_reg)
                PH_SPACE:
                begin
                    if (is_space)
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (text_byte == CH_PLUS || text_byte == CH_MINUS)
                    begin
                        neg_next   = (text_byte == CH_MINUS);
                        phase_next = PH_START;
                    end
                    else
                    begin
                        take_start = 1'b1;
                    end
                end
                PH_START:
                begin
                    take_start = 1'b1;
                end
                PH_ZERO:
                begin
                    if (text_byte == CH_LO_X || text_byte == CH_UP_X)
                    begin
                        base_next  = BASE_HEX;
                        phase_next = PH_AFTER_X;
                    end
                    else
                    begin
                        // The lone zero counts as a digit.
                        dig_base  = (base_reg == BASE_AUTO) ? BASE_OCT : base_reg;
                        base_next = dig_base;
                        ce_next   = ds_reg;
                        use_digit = 1'b1;
                    end
                end
                PH_AFTER_X:
                begin
                    // Without a hex digit the length ends just after the zero.
                    dig_base  = BASE_HEX;
                    ce_next   = ds_reg;
                    use_digit = 1'b1;
                end
                PH_DIGITS:
                begin
                    use_digit = 1'b1;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            // First character after whitespace and sign.
            if (take_start)
            begin
                if (radix_bad)
                begin
                    phase_next = PH_DONE;
                end
                else if (text_byte == CH_ZERO && (radix == BASE_AUTO || radix == BASE_HEX))
                begin
                    base_next  = radix;
                    ds_next    = pos_next;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    dig_base  = (radix == BASE_AUTO) ? BASE_DEC : radix;
                    base_next = dig_base;
                    use_digit = 1'b1;
                end
            end

            // One multiply-add per character; the exact sum also gives the overflow test.
            dig_ok = dig.ok && (dig.value < dig_base);
            mac    = MAC_W'(acc_reg) * MAC_W'(dig_base) + MAC_W'(dig.value);

            // Digit accumulation or stop.
            if (use_digit)
            begin
                if (dig_ok)
                begin
                    acc_next   = mac[VALUE_BITS-1:0];
                    ovf_next   = ovf_reg || (|mac[MAC_W-1:VALUE_BITS-1]);
                    ce_next    = pos_next;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Result assembly at the end of a text.
    assign text_end   = (text_byte == CH_NUL) || last_byte;
    assign emit       = step && text_end;
    assign ce_final   = (phase_next == PH_ZERO || phase_next == PH_AFTER_X) ? ds_next : ce_next;
    assign mag_signed = neg_next ? (VALUE_BITS'(0) - acc_next) : acc_next;
    assign val_s      = signed'(mag_signed);

    assign res.parsed_value    = OUT_VALUE_W'(val_s);
    assign res.consumed_length = LENGTH_W'(ce_final);
    assign res.overflow        = ovf_next;

    // State update; the state clears after each result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            acc_reg   <= '0;
            pos_reg   <= '0;
            ds_reg    <= '0;
            ce_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (text_end)
            begin
                phase_reg <= PH_SPACE;
                neg_reg   <= 1'b0;
                base_reg  <= '0;
                acc_reg   <= '0;
                pos_reg   <= '0;
                ds_reg    <= '0;
                ce_reg    <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                pos_reg   <= pos_next;
                ds_reg    <= ds_next;
                ce_reg    <= ce_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

@@ hw/rtl/radix_text_to_integer_parser.sv @@
// A text's final word passes the input word register; its result enters the result register.
// Throughput: one character word per cycle without result stalls; at most one result per text.
// The rate is set by the single multiply-add on the accumulator in each cycle.
// Reset (rst_n low, asynchronous) empties both word registers, clears the text state
// and sets the radix register to 10.
`include "radix_text_to_integer_parser_macros.svh"

module radix_text_to_integer_parser
    import rtip_pkg::*;
#(
    parameter int VALUE_BITS    = VALUE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    rtip_text_if.sink             text,
    rtip_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [RADIX_W-1:0] radix;
    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_last_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg;
    result_t            core_res;
    logic               core_emit;
    logic               advance;

    // Configuration register.
    rtip_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radix   (radix)
    );

    // The stage moves whenever the result register is empty or being taken.
    assign advance    = !out_valid_reg || result.ready;
    assign text.ready = !in_valid_reg || advance;

    // Input word register.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (text.ready)
        begin
            in_valid_next = text.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            in_byte_reg <= text.text_byte;
            in_last_reg <= text.last_byte;
        end
    end

    // Parse state and per-character logic.
    rtip_core #(
        .VALUE_BITS    (VALUE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_valid_reg && advance),
        .text_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .radix     (radix),
        .emit      (core_emit),
        .res       (core_res)
    );

    // Result word register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = core_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_emit)
        begin
            out_res_reg <= core_res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.parsed_value    = out_res_reg.parsed_value;
    assign result.consumed_length = out_res_reg.consumed_length;
    assign result.overflow        = out_res_reg.overflow;

    // A held input word is not dropped while the result side stalls.
    `RTIP_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg)
    // With the result register empty the block always takes a new word.
    `RTIP_ASSERT(a_ready_when_empty, !out_valid_reg |-> text.ready)
    // A result only comes from a held input word.
    `RTIP_ASSERT(a_emit_from_word, core_emit |-> in_valid_reg)

endmodule
